/* rtl/core/ut_pkg.sv */
// shared types and constants of the unicode transcoder
// used by the decode stage, the output buffer, the checker and the bench
package ut_pkg;

  // width of the converted code point counter, 8 to 32
  localparam int unsigned CountWidth = 16;

  // maximum number of output words caused by one input word
  localparam int unsigned MaxRes = 4;

  typedef enum logic [1:0] {
    FmtUcs2  = 2'd0,
    FmtUtf32 = 2'd1,
    FmtUtf16 = 2'd2,
    FmtUtf8  = 2'd3
  } fmt_e;

  typedef enum logic [1:0] {
    StData  = 2'd0,
    StUnrep = 2'd1,
    StTrunc = 2'd2
  } status_e;

  // configuration register indexes
  localparam logic [1:0] RegSrcFmt = 2'd0;
  localparam logic [1:0] RegTgtFmt = 2'd1;

  // reset values of the format registers
  localparam fmt_e SrcFmtReset = FmtUtf8;
  localparam fmt_e TgtFmtReset = FmtUtf32;

  // output words of one input word, handed from decode to the buffer
  typedef struct packed {
    logic [MaxRes-1:0][7:0] data;
    logic [2:0]             nres;
    status_e                status;
  } result_t;

endpackage

/* rtl/core/ut_in_if.sv */
// input word channel of the unicode transcoder
// carries valid, ready and one source byte with its end flag
interface ut_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport src (output valid, in_byte, end_of_input, input ready);
  modport snk (input valid, in_byte, end_of_input, output ready);
endinterface

/* rtl/core/ut_out_if.sv */
// output word channel of the unicode transcoder
// carries valid, ready and one encoded byte with status and count
interface ut_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  status;
  logic        last_of_run;
  logic [15:0] converted_count;

  modport src (output valid, out_byte, status, last_of_run, converted_count, input ready);
  modport snk (input valid, out_byte, status, last_of_run, converted_count, output ready);
endinterface

/* rtl/core/ut_decode.sv */
// unit gathering, surrogate pairing and target encoding for one input word
// holds the format registers and the unit state; depends on ut_pkg
module ut_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [1:0]         cfg_data_i,
  input  logic               accept_i,
  input  logic [7:0]         in_byte_i,
  input  logic               eoi_i,
  output ut_pkg::result_t    res_o,
  output logic [15:0]        count_o
);

  ut_pkg::fmt_e src_fmt_q, tgt_fmt_q;
  logic [31:0] acc_q;
  logic [1:0]  bg_q;
  logic [2:0]  exp_q;
  logic [15:0] hi_q;
  logic        pend_q;
  logic [ut_pkg::CountWidth-1:0] cnt_q, cnt_d;

  logic [31:0] acc_d;
  logic [2:0]  len_d;
  logic [2:0]  got;
  logic        complete;
  logic        do_emit, do_hold, do_trunc, bump;
  logic [31:0] cp, v;
  logic [15:0] hs, ls;
  ut_pkg::result_t res;

  // gather the next byte into the unit
  always_comb begin
    acc_d = acc_q;
    len_d = exp_q;
    got   = {1'b0, bg_q} + 3'd1;
    if (exp_q == 3'd0) begin
      got   = 3'd1;
      acc_d = {24'd0, in_byte_i};
      unique case (src_fmt_q)
        ut_pkg::FmtUtf32: len_d = 3'd4;
        ut_pkg::FmtUtf8: begin
          if (in_byte_i < 8'h80) begin
            len_d = 3'd1;
          end else if (in_byte_i < 8'hE0) begin
            len_d = 3'd2;
            acc_d = {27'd0, in_byte_i[4:0]};
          end else if (in_byte_i < 8'hF0) begin
            len_d = 3'd3;
            acc_d = {28'd0, in_byte_i[3:0]};
          end else begin
            len_d = 3'd4;
            acc_d = {29'd0, in_byte_i[2:0]};
          end
        end
        default: len_d = 3'd2;
      endcase
    end else if (src_fmt_q == ut_pkg::FmtUtf8) begin
      acc_d = {acc_q[25:0], in_byte_i[5:0]};
    end else begin
      acc_d = acc_q | ({24'd0, in_byte_i} << {bg_q, 3'b000});
    end
    complete = (got >= len_d);
  end

  // pick the code point, pairing surrogates in utf-16 input
  always_comb begin
    do_emit  = 1'b0;
    do_hold  = 1'b0;
    do_trunc = 1'b0;
    cp       = acc_d;
    if (complete) begin
      if (src_fmt_q != ut_pkg::FmtUtf16) begin
        do_emit = 1'b1;
      end else if (pend_q) begin
        do_emit = 1'b1;
        if (acc_d >= 32'hDC00 && acc_d <= 32'hDFFF) begin
          cp = 32'h10000 + {12'd0, hi_q[9:0], acc_d[9:0]};
        end else begin
          cp = {16'd0, hi_q};
        end
      end else if (acc_d >= 32'hD800 && acc_d <= 32'hDBFF && !eoi_i) begin
        do_hold = 1'b1;
      end else begin
        do_emit = 1'b1;
      end
    end else begin
      do_trunc = eoi_i;
    end
  end

  // encode in the target format
  always_comb begin
    res.data   = '0;
    res.nres   = 3'd0;
    res.status = ut_pkg::StData;
    bump       = 1'b0;
    v          = cp - 32'h10000;
    hs         = 16'hD800 + v[25:10];
    ls         = {6'b110111, v[9:0]};
    if (do_emit) begin
      bump = 1'b1;
      unique case (tgt_fmt_q)
        ut_pkg::FmtUcs2: begin
          if (cp > 32'hFFFF) begin
            res.nres   = 3'd1;
            res.status = ut_pkg::StUnrep;
            bump       = 1'b0;
          end else begin
            res.nres    = 3'd2;
            res.data[0] = cp[7:0];
            res.data[1] = cp[15:8];
          end
        end
        ut_pkg::FmtUtf32: begin
          res.nres = 3'd4;
          res.data = cp;
        end
        ut_pkg::FmtUtf16: begin
          if (cp < 32'h10000) begin
            res.nres    = 3'd2;
            res.data[0] = cp[7:0];
            res.data[1] = cp[15:8];
          end else begin
            res.nres = 3'd4;
            res.data = {ls, hs};
          end
        end
        default: begin
          if (cp < 32'h80) begin
            res.nres    = 3'd1;
            res.data[0] = cp[7:0];
          end else if (cp < 32'h800) begin
            res.nres    = 3'd2;
            res.data[0] = 8'hC0 | cp[13:6];
            res.data[1] = {2'b10, cp[5:0]};
          end else if (cp < 32'h10000) begin
            res.nres    = 3'd3;
            res.data[0] = 8'hE0 | cp[19:12];
            res.data[1] = {2'b10, cp[11:6]};
            res.data[2] = {2'b10, cp[5:0]};
          end else begin
            res.nres    = 3'd4;
            res.data[0] = 8'hF0 | cp[25:18];
            res.data[1] = {2'b10, cp[17:12]};
            res.data[2] = {2'b10, cp[11:6]};
            res.data[3] = {2'b10, cp[5:0]};
          end
        end
      endcase
    end else if (do_trunc) begin
      res.nres   = 3'd1;
      res.status = ut_pkg::StTrunc;
    end
  end

  // saturating count of converted code points
  always_comb begin
    cnt_d = cnt_q;
    if (bump && cnt_q != '1) begin
      cnt_d = cnt_q + {{(ut_pkg::CountWidth-1){1'b0}}, 1'b1};
    end
  end

  assign res_o   = res;
  assign count_o = 16'(cnt_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_fmt_q <= ut_pkg::SrcFmtReset;
      tgt_fmt_q <= ut_pkg::TgtFmtReset;
      acc_q     <= '0;
      bg_q      <= '0;
      exp_q     <= '0;
      hi_q      <= '0;
      pend_q    <= 1'b0;
      cnt_q     <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ut_pkg::RegSrcFmt) begin
        // format change drops any partial unit and held surrogate
        src_fmt_q <= ut_pkg::fmt_e'(cfg_data_i);
        acc_q     <= '0;
        bg_q      <= '0;
        exp_q     <= '0;
        hi_q      <= '0;
        pend_q    <= 1'b0;
      end else if (cfg_idx_i == ut_pkg::RegTgtFmt) begin
        tgt_fmt_q <= ut_pkg::fmt_e'(cfg_data_i);
      end
    end else if (accept_i) begin
      if (eoi_i) begin
        acc_q  <= '0;
        bg_q   <= '0;
        exp_q  <= '0;
        hi_q   <= '0;
        pend_q <= 1'b0;
        cnt_q  <= '0;
      end else begin
        cnt_q <= cnt_d;
        if (complete) begin
          acc_q <= '0;
          bg_q  <= '0;
          exp_q <= '0;
          if (do_hold) begin
            hi_q   <= acc_d[15:0];
            pend_q <= 1'b1;
          end else if (src_fmt_q == ut_pkg::FmtUtf16) begin
            hi_q   <= '0;
            pend_q <= 1'b0;
          end
        end else begin
          acc_q <= acc_d;
          bg_q  <= got[1:0];
          exp_q <= len_d;
        end
      end
    end
  end

endmodule

/* rtl/core/ut_outbuf.sv */
// result register holding the output words of one input word,
// handed out one per cycle while ready; needs ut_pkg, ut_out_if
module ut_outbuf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  ut_pkg::result_t res_i,
  input  logic [15:0]     count_i,
  output logic            in_ready_o,
  ut_out_if.src           res_o
);

  logic                            busy_q;
  logic [1:0]                      idx_q;
  logic [ut_pkg::MaxRes-1:0][7:0]  data_q;
  logic [2:0]                      nres_q;
  ut_pkg::status_e                 status_q;
  logic [15:0]                     count_q;
  logic                            fire, last, drain;

  assign last  = ({1'b0, idx_q} == (nres_q - 3'd1));
  assign fire  = busy_q && res_o.ready;
  assign drain = fire && last;

  // takes a word when idle or as the last buffered word leaves
  assign in_ready_o = !busy_q || drain;

  assign res_o.valid           = busy_q;
  assign res_o.out_byte        = data_q[idx_q];
  assign res_o.status          = status_q;
  assign res_o.last_of_run     = last;
  assign res_o.converted_count = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (drain) begin
      busy_q <= 1'b0;
    end else if (fire) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q   <= res_i.data;
      nres_q   <= res_i.nres;
      status_q <= res_i.status;
      count_q  <= count_i;
    end
  end

endmodule

/* rtl/core/unicode_transcoder_top.sv */
// top level of the unicode transcoder
// uses ut_pkg, ut_in_if, ut_out_if, ut_decode and ut_outbuf
//
// usage
// - src_i brings one source byte per word, with end_of_input on the last
//   byte of a buffer; res_o gives the target bytes, one per word
// - cfg_we_i writes register cfg_idx_i: 0 source format, 1 target format
//   (0 ucs-2le, 1 utf-32le, 2 utf-16le, 3 utf-8); other indexes are ignored;
//   write only while no output word is pending
// - an input word is decoded and encoded in the cycle it is accepted; its
//   output words appear on res_o from the next cycle
// - an input word causes 0 to 4 output words; res_o sends one per cycle
//   while res_o is ready, and a new word is taken in the same cycle the
//   last buffered word leaves
// - words that only add to a partial unit or hold a high surrogate
//   produce nothing and pass at one per cycle unless output words are pending
// - status 1 flags a code point above 0xffff aimed at ucs-2, status 2 a
//   truncated unit at end of input; both carry a zero byte
// - converted_count counts code points since the last end of input
// - reset selects utf-8 in, utf-32le out and clears all unit state;
//   when res_o stalls, the buffered words hold and src_i is not ready
module unicode_transcoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  ut_in_if.snk       src_i,
  ut_out_if.src      res_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [1:0] cfg_data_i
);

  ut_pkg::result_t res;
  logic [15:0]     count;
  logic            in_ready;
  logic            accept;

  assign src_i.ready = in_ready;
  assign accept      = src_i.valid && in_ready;

  // decode and encode the accepted byte, update unit state
  ut_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .in_byte_i  (src_i.in_byte),
    .eoi_i      (src_i.end_of_input),
    .res_o      (res),
    .count_o    (count)
  );

  // only words with output are loaded into the result register
  ut_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept && (res.nres != 3'd0)),
    .res_i      (res),
    .count_i    (count),
    .in_ready_o (in_ready),
    .res_o      (res_o)
  );

endmodule

/* rtl/core/ut_checker.sv */
// port level checks of the unicode transcoder
// bound to unicode_transcoder_top; depends on ut_pkg
module ut_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        src_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [7:0]  out_byte_i,
  input logic [1:0]  status_i,
  input logic        last_i,
  input logic [15:0] count_i
);

  // a stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(out_byte_i) && $stable(status_i))
    else $error("stalled output word changed");

  // flagged words carry a zero byte and stand alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && status_i != ut_pkg::StData |-> out_byte_i == 8'd0 && last_i)
    else $error("flagged word malformed");

  // a run continues in the next cycle with the same count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && !last_i |=> res_valid_i && $stable(count_i))
    else $error("run broken");

  // no input is taken while an output word waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |-> !src_ready_i)
    else $error("input taken during output stall");

endmodule

bind unicode_transcoder_top ut_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .src_ready_i (src_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .out_byte_i  (res_o.out_byte),
  .status_i    (res_o.status),
  .last_i      (res_o.last_of_run),
  .count_i     (res_o.converted_count)
);

/* test/tb_top.sv */
// self-checking bench of the unicode transcoder, top module tb_top
// depends on ut_pkg, ut_in_if, ut_out_if and unicode_transcoder_top
// directed and random byte streams, results checked against a local transcoder
`timescale 1ns / 100ps

module tb_top;

  // register indexes the block ignores
  localparam logic [1:0] RegSpareA = 2'd2;
  localparam logic [1:0] RegSpareB = 2'd3;

  localparam int unsigned TotalItems  = 130;  // stimulus stops near this many bytes
  localparam int unsigned HoldCycles  = 64;   // long receiver hold-off
  localparam int unsigned DrainCycles = 8;    // idle cycles after the last word
  localparam int unsigned QuietLimit  = 2000; // cycles with no handshake at all

  // one expected output word
  typedef struct packed {
    logic [7:0]      out_byte;
    ut_pkg::status_e status;
    logic            last_of_run;
    logic [15:0]     converted_count;
  } word_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [1:0] cfg_data_i;

  ut_in_if  src_if ();
  ut_out_if res_if ();

  unicode_transcoder_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .src_i      (src_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // ---------------------------------------------------------------------
  // local transcoder: format registers and unit state, as after reset
  // ---------------------------------------------------------------------
  ut_pkg::fmt_e src_fmt;
  ut_pkg::fmt_e tgt_fmt;
  logic [31:0] unit_acc;     // code unit being gathered
  logic [1:0]  n_gathered;   // bytes of the unit taken so far
  logic [2:0]  unit_len;     // bytes in the unit, zero when none in progress
  logic [15:0] held_hi;      // high surrogate waiting for its partner
  logic        hi_pending;
  logic [31:0] cp_count;     // code points since last end of input

  word_t run_words[$];       // words caused by the current byte
  word_t pending_words[$];   // words predicted but not yet seen on res_o

  int unsigned bytes_sent;
  int unsigned error_cnt;
  int unsigned burst_left;
  bit          hold_req;     // asks the receiver for one long hold-off

  function automatic void clear_unit();
    unit_acc   = '0;
    n_gathered = '0;
    unit_len   = '0;
    held_hi    = '0;
    hi_pending = 1'b0;
  endfunction

  // one output word of the current byte, at most four per byte
  function automatic void add_word(input logic [31:0] v,
                                   input ut_pkg::status_e st = ut_pkg::StData);
    word_t w;
    if (run_words.size() >= ut_pkg::MaxRes) return;
    w.out_byte        = v[7:0];
    w.status          = st;
    w.last_of_run     = 1'b0;
    w.converted_count = '0;
    run_words.push_back(w);
  endfunction

  // write one code point in the target format and count it
  function automatic void encode_cp(input logic [31:0] cp);
    logic [31:0] v;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] cnt_max;
    cnt_max = (ut_pkg::CountWidth >= 32) ? 32'hFFFF_FFFF
                                         : (32'd1 << ut_pkg::CountWidth) - 32'd1;
    case (tgt_fmt)
      ut_pkg::FmtUcs2: begin
        // above the basic plane: flagged, not counted
        if (cp > 32'hFFFF) begin
          add_word(32'd0, ut_pkg::StUnrep);
          return;
        end
        add_word(cp);
        add_word(cp >> 8);
      end
      ut_pkg::FmtUtf32: begin
        add_word(cp);
        add_word(cp >> 8);
        add_word(cp >> 16);
        add_word(cp >> 24);
      end
      ut_pkg::FmtUtf16: begin
        if (cp < 32'h10000) begin
          add_word(cp);
          add_word(cp >> 8);
        end else begin
          // pair arithmetic on 32 bits, bytes cut to 8 bits
          v  = cp - 32'h10000;
          hi = 32'hD800 + (v >> 10);
          lo = 32'hDC00 + (v & 32'h3FF);
          add_word(hi);
          add_word(hi >> 8);
          add_word(lo);
          add_word(lo >> 8);
        end
      end
      default: begin
        if (cp < 32'h80) begin
          add_word(cp);
        end else if (cp < 32'h800) begin
          add_word(32'hC0 | (cp >> 6));
          add_word(32'h80 | (cp & 32'h3F));
        end else if (cp < 32'h10000) begin
          add_word(32'hE0 | (cp >> 12));
          add_word(32'h80 | ((cp >> 6) & 32'h3F));
          add_word(32'h80 | (cp & 32'h3F));
        end else begin
          add_word(32'hF0 | (cp >> 18));
          add_word(32'h80 | ((cp >> 12) & 32'h3F));
          add_word(32'h80 | ((cp >> 6) & 32'h3F));
          add_word(32'h80 | (cp & 32'h3F));
        end
      end
    endcase
    if (cp_count < cnt_max) cp_count++;
  endfunction

  // take one accepted source byte, queue the words it causes
  function automatic void transcode_byte(input logic [7:0] b, input logic eoi);
    logic [2:0]  got;
    logic [31:0] unit;
    logic [31:0] hi;
    run_words.delete();

    if (unit_len == 3'd0) begin
      // first byte of a unit; in utf-8 the lead byte fixes the length
      unit_acc = {24'd0, b};
      case (src_fmt)
        ut_pkg::FmtUtf32: unit_len = 3'd4;
        ut_pkg::FmtUtf8: begin
          if (b < 8'h80) begin
            unit_len = 3'd1;
          end else if (b < 8'hE0) begin
            unit_len = 3'd2;
            unit_acc = {27'd0, b[4:0]};
          end else if (b < 8'hF0) begin
            unit_len = 3'd3;
            unit_acc = {28'd0, b[3:0]};
          end else begin
            unit_len = 3'd4;
            unit_acc = {29'd0, b[2:0]};
          end
        end
        default: unit_len = 3'd2;
      endcase
      got = 3'd1;
    end else begin
      // continuation bytes are not checked, only their low six bits count
      if (src_fmt == ut_pkg::FmtUtf8) unit_acc = (unit_acc << 6) | {26'd0, b[5:0]};
      else unit_acc = unit_acc | ({24'd0, b} << (n_gathered * 8));
      got = {1'b0, n_gathered} + 3'd1;
    end

    if (got >= unit_len) begin
      unit       = unit_acc;
      unit_acc   = '0;
      n_gathered = '0;
      unit_len   = '0;
      if (src_fmt != ut_pkg::FmtUtf16) begin
        encode_cp(unit);
      end else if (hi_pending) begin
        // a held high surrogate pairs up, or goes out alone and the unit is lost
        hi         = {16'd0, held_hi};
        hi_pending = 1'b0;
        held_hi    = '0;
        if (unit >= 32'hDC00 && unit <= 32'hDFFF)
          encode_cp(32'h10000 + ((hi - 32'hD800) << 10) + (unit - 32'hDC00));
        else
          encode_cp(hi);
      end else if (unit >= 32'hD800 && unit <= 32'hDBFF && !eoi) begin
        held_hi    = unit[15:0];
        hi_pending = 1'b1;
      end else begin
        encode_cp(unit);
      end
    end else begin
      n_gathered = got[1:0];
      if (eoi) add_word(32'd0, ut_pkg::StTrunc);
    end

    foreach (run_words[k]) begin
      run_words[k].last_of_run     = (k == run_words.size() - 1);
      run_words[k].converted_count = cp_count[15:0];
      pending_words.push_back(run_words[k]);
    end

    if (eoi) begin
      clear_unit();
      cp_count = '0;
    end
  endfunction

  // ---------------------------------------------------------------------
  // clock, watchdog
  // ---------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ends the run when no word moves on either channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((src_if.valid && src_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // predictor hook: every accepted source word goes through the model
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && src_if.valid && src_if.ready)
      transcode_byte(src_if.in_byte, src_if.end_of_input);
  end

  // ---------------------------------------------------------------------
  // result check: each output word against the oldest prediction
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : check_words
    word_t exp_w;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected output word: out_byte %0h status %0d",
               res_if.out_byte, res_if.status);
        error_cnt++;
      end else begin
        exp_w = pending_words.pop_front();
        if (res_if.out_byte !== exp_w.out_byte) begin
          $error("out_byte: expected %0h, got %0h", exp_w.out_byte, res_if.out_byte);
          error_cnt++;
        end
        if (res_if.status !== exp_w.status) begin
          $error("status: expected %0d, got %0d", exp_w.status, res_if.status);
          error_cnt++;
        end
        if (res_if.last_of_run !== exp_w.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", exp_w.last_of_run,
                 res_if.last_of_run);
          error_cnt++;
        end
        if (res_if.converted_count !== exp_w.converted_count) begin
          $error("converted_count: expected %0d, got %0d", exp_w.converted_count,
                 res_if.converted_count);
          error_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // receiver: stretches of steady, random, sparse or toggling ready,
  // plus one long hold-off on request
  // ---------------------------------------------------------------------
  initial begin : receiver
    int unsigned mode;
    int unsigned stretch;
    bit          toggle;
    res_if.ready <= 1'b0;
    mode    = 0;
    stretch = 0;
    toggle  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        // hold-off counted here, the sender keeps offering meanwhile
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      if (stretch == 0) begin
        mode    = $urandom_range(0, 3);
        stretch = $urandom_range(5, 40);
      end
      stretch--;
      case (mode)
        0: res_if.ready <= 1'b1;
        1: res_if.ready <= 1'($urandom_range(0, 1));
        2: res_if.ready <= ($urandom_range(0, 3) == 0);
        default: begin
          res_if.ready <= toggle;
          toggle = ~toggle;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------

  // offer one source word, in bursts with random gaps; valid stays high
  // after acceptance so back-to-back words go out without a gap
  task automatic send_byte(input logic [7:0] b, input logic eoi);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        src_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    src_if.valid        <= 1'b1;
    src_if.in_byte      <= b;
    src_if.end_of_input <= eoi;
    @(posedge clk_i);
    while (!src_if.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  // send the n low bytes of seq, most significant first, end flag on the last
  task automatic send_bytes(input logic [31:0] seq, input int unsigned n,
                            input logic eoi_last);
    for (int i = int'(n) - 1; i >= 0; i--)
      send_byte(seq[8*i +: 8], eoi_last && (i == 0));
  endtask

  // stop sending and wait until every predicted word has come out
  task automatic drain_results();
    src_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // register write, only called with the block drained
  task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ut_pkg::RegSrcFmt) begin
      // a new source format abandons any partial unit, count is kept
      src_fmt = ut_pkg::fmt_e'(val);
      clear_unit();
    end else if (idx == ut_pkg::RegTgtFmt) begin
      tgt_fmt = ut_pkg::fmt_e'(val);
    end
    @(posedge clk_i);
  endtask

  task automatic set_formats(input ut_pkg::fmt_e src, input ut_pkg::fmt_e tgt);
    drain_results();
    write_reg(ut_pkg::RegSrcFmt, src);
    write_reg(ut_pkg::RegTgtFmt, tgt);
  endtask

  // one code point in the current source format, mostly well formed;
  // sometimes cut short by a byte or replaced by a lone noise byte
  task automatic send_random_unit(input logic eoi_last);
    logic [31:0] seq;
    logic [31:0] cp;
    logic [15:0] hi;
    logic [15:0] lo;
    logic [7:0]  c;
    int unsigned n;
    if ($urandom_range(0, 9) == 0) begin
      send_byte(8'($urandom_range(0, 255)), eoi_last);
      return;
    end
    case (src_fmt)
      ut_pkg::FmtUcs2: begin
        seq = {16'd0, 16'($urandom_range(0, 16'hFFFF))};
        n   = 2;
      end
      ut_pkg::FmtUtf32: begin
        cp  = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h10FFFF);
        seq = {cp[7:0], cp[15:8], cp[23:16], cp[31:24]};
        n   = 4;
      end
      ut_pkg::FmtUtf16: begin
        hi = 16'hD800 + 16'($urandom_range(0, 16'h3FF));
        case ($urandom_range(0, 3))
          0: lo = 16'($urandom_range(0, 16'hFFFF));           // broken pair
          1: begin                                            // basic plane unit
            lo = 16'($urandom_range(0, 16'hFFFF));
            hi = 16'd0;
          end
          default: lo = 16'hDC00 + 16'($urandom_range(0, 16'h3FF));
        endcase
        if (hi == 16'd0) begin
          seq = {16'd0, lo[7:0], lo[15:8]};
          n   = 2;
        end else begin
          seq = {hi[7:0], hi[15:8], lo[7:0], lo[15:8]};
          n   = 4;
        end
      end
      default: begin
        n = $urandom_range(1, 4);
        case (n)
          1: seq = $urandom_range(0, 8'h7F);
          2: seq = $urandom_range(8'h80, 8'hDF);   // stray continuations too
          3: seq = 8'hE0 + $urandom_range(0, 15);
          default: seq = 8'hF0 + $urandom_range(0, 15);
        endcase
        for (int i = 1; i < int'(n); i++) begin
          c   = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'h80 | 8'($urandom_range(0, 63));
          seq = {seq[23:0], c};
        end
      end
    endcase
    if (n > 1 && $urandom_range(0, 7) == 0) begin
      // drop the final byte, leaves a partial unit behind
      seq = seq >> 8;
      n--;
    end
    send_bytes(seq, n, eoi_last);
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // reset formats: utf-8 in, utf-32 out; lead byte classes, huge lead,
  // stray continuation cut off by the end of input
  task automatic test_reset_formats();
    send_bytes(32'h00, 1, 1'b0);
    send_bytes(32'h7F, 1, 1'b0);
    send_bytes(32'hE282AC, 3, 1'b0);
    send_bytes(32'hFFBFBFBF, 4, 1'b0);
    send_bytes(32'h80, 1, 1'b1);
  endtask

  // code point above the basic plane aimed at ucs-2
  task automatic test_ucs2_overflow();
    set_formats(ut_pkg::FmtUtf32, ut_pkg::FmtUcs2);
    send_bytes(32'h00000100, 4, 1'b1);
  endtask

  // pair, broken pair, high surrogate closing the buffer
  task automatic test_surrogates();
    set_formats(ut_pkg::FmtUtf16, ut_pkg::FmtUtf16);
    send_bytes(32'h3DD800DE, 4, 1'b0);
    send_bytes(32'hFFDB4100, 4, 1'b0);
    send_bytes(32'h00D8, 2, 1'b1);
  endtask

  // widest basic plane value and nul into utf-8
  task automatic test_utf8_out();
    set_formats(ut_pkg::FmtUcs2, ut_pkg::FmtUtf8);
    send_bytes(32'hFFFF, 2, 1'b0);
    send_bytes(32'h0000, 2, 1'b1);
  endtask

  // source write drops a partial unit; spare indexes change nothing
  task automatic test_format_switch();
    set_formats(ut_pkg::FmtUtf8, ut_pkg::FmtUtf8);
    send_byte(8'hE2, 1'b0);
    drain_results();
    write_reg(ut_pkg::RegSrcFmt, ut_pkg::FmtUtf8);
    write_reg(RegSpareA, 2'd0);
    write_reg(RegSpareB, 2'd3);
    send_byte(8'h41, 1'b1);
  endtask

  // receiver holds off while ascii expands to four words each,
  // then the sender waits for every word to come out
  task automatic test_backpressure();
    set_formats(ut_pkg::FmtUtf8, ut_pkg::FmtUtf32);
    hold_req = 1'b1;
    for (int i = 0; i < 16; i++) send_byte(8'($urandom_range(0, 8'h7F)), i == 15);
    drain_results();
  endtask

  // random format phases with mostly well formed units
  task automatic test_random_phases();
    int unsigned units;
    while (bytes_sent < TotalItems) begin
      drain_results();
      write_reg(ut_pkg::RegSrcFmt, 2'($urandom_range(0, 3)));
      write_reg(ut_pkg::RegTgtFmt, 2'($urandom_range(0, 3)));
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? RegSpareA : RegSpareB, 2'($urandom_range(0, 3)));
      units = $urandom_range(2, 8);
      for (int u = 0; u < int'(units); u++)
        send_random_unit((u == int'(units) - 1) && ($urandom_range(0, 3) != 0));
    end
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    // model and all block inputs known from the first instant
    src_fmt    = ut_pkg::SrcFmtReset;
    tgt_fmt    = ut_pkg::TgtFmtReset;
    clear_unit();
    cp_count   = '0;
    bytes_sent = 0;
    error_cnt  = 0;
    burst_left = 0;
    hold_req   = 1'b0;
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= ut_pkg::RegSrcFmt;
    cfg_data_i          <= '0;
    src_if.valid        <= 1'b0;
    src_if.in_byte      <= '0;
    src_if.end_of_input <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_formats();
    test_ucs2_overflow();
    test_surrogates();
    test_utf8_out();
    test_format_switch();
    test_backpressure();
    test_random_phases();

    drain_results();
    if (error_cnt == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
